@@ src/mpw_pkg.sv @@
package mpw_pkg;

  // Default sizes of the feature store and of the window hardware.
  localparam int MAX_HEIGHT_DEF   = 32;
  localparam int MAX_WIDTH_DEF    = 32;
  localparam int MAX_CHANNELS_DEF = 16;
  localparam int MAX_KERNEL_DEF   = 8;
  localparam int MAX_STRIDE_DEF   = 8;

  // Field widths of the stream payloads and the configuration port.
  localparam int SAMPLE_W   = 16;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int CHAN_W     = 4;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  // Bit positions of the input fields inside the input tdata.
  localparam int ROW_LSB    = 0;
  localparam int COL_LSB    = ROW_LSB + ROW_W;
  localparam int CHAN_LSB   = COL_LSB + COL_W;
  localparam int SAMPLE_LSB = CHAN_LSB + CHAN_W;

  // Lowest signed sample, the starting point of every maximum.
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_FLOOR = 16'sh8000;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_POOL = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_HEIGHT    = 3'd0,
    REG_MAP_WIDTH     = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_KERNEL_WIDTH  = 3'd4,
    REG_STRIDE_ROWS   = 3'd5,
    REG_STRIDE_COLS   = 3'd6,
    REG_ROUND_UP      = 3'd7
  } reg_index_t;

endpackage

@@ src/max_pool_window_unit.sv @@
// Channel   Direction  Handshake                         Payload
// s_axis    in         s_axis_tvalid / s_axis_tready     tdata: row, col, channel, sample
//                                                        tuser: operation
// m_axis    out        m_axis_tvalid / m_axis_tready     tdata: max_value; tuser: in_range
// cfg       in         cfg_valid / cfg_ready             cfg_index, cfg_data
//
// A load that falls inside the map is written as it is accepted; the block stays ready.
// A pool scans the window cells and emits the result, or goes straight to emit if
// the cell is out of range or the window is empty; the store gives one cell a cycle.
// Reset (rst, synchronous) restores the register defaults; the store is not cleared.
// A result waits in the output register; while it is not taken the next pool
// holds in its final cycle.
module max_pool_window_unit #(
  parameter int MAX_HEIGHT   = mpw_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH    = mpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = mpw_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_KERNEL   = mpw_pkg::MAX_KERNEL_DEF,
  parameter int MAX_STRIDE   = mpw_pkg::MAX_STRIDE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Fields from bit 0 up: row[4:0], col[9:5], channel[13:10], sample[29:14], zeros.
  input  logic [mpw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0 up: operation[0].
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Fields from bit 0 up: max_value[15:0].
  output logic [mpw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0 up: in_range[0].
  output logic [0:0]                       m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpw_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mpw_pkg::*;

  // Address field widths of the feature store.
  localparam int RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW = RB + CB + HB;
  localparam int DEPTH = 1 << AW;

  // Coordinate width: covers row * stride + kernel offset and every address field.
  localparam int PW0 = ROW_W + 4 + 1;
  localparam int PW1 = (PW0 > RB) ? PW0 : RB;
  localparam int PW2 = (PW1 > CB) ? PW1 : CB;
  localparam int PW  = (PW2 > HB) ? PW2 : HB;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // Configuration registers.
  logic [5:0] map_height;
  logic [5:0] map_width;
  logic [4:0] channel_count;
  logic [3:0] kernel_height;
  logic [3:0] kernel_width;
  logic [3:0] stride_rows;
  logic [3:0] stride_cols;
  logic       round_up;

  // Sequencer and datapath registers.
  state_t                      state;
  logic [PW-1:0]               base_r;
  logic [PW-1:0]               base_c;
  logic [CHAN_W-1:0]           chan;
  logic                        in_ok;
  logic [3:0]                  i_cnt;
  logic [3:0]                  j_cnt;
  logic signed [SAMPLE_W-1:0]  best;
  logic                        rd_live;
  logic signed [SAMPLE_W-1:0]  rd_data;
  logic signed [SAMPLE_W-1:0]  feature_mem [DEPTH];

  // Combinational signals.
  logic [5:0]                  h_cap;
  logic [5:0]                  w_cap;
  logic [4:0]                  nc_cap;
  logic [3:0]                  kh_cap;
  logic [3:0]                  kw_cap;
  logic [3:0]                  sr_cap;
  logic [3:0]                  sc_cap;
  logic [3:0]                  sr;
  logic [3:0]                  sc;
  logic [ROW_W-1:0]            in_row;
  logic [COL_W-1:0]            in_col;
  logic [CHAN_W-1:0]           in_chan;
  logic signed [SAMPLE_W-1:0]  in_sample;
  logic [PW-1:0]               row_ext;
  logic [PW-1:0]               col_ext;
  logic [PW-1:0]               chan_in_ext;
  logic [PW-1:0]               chan_ext;
  logic [PW-1:0]               prod_r;
  logic [PW-1:0]               prod_c;
  logic                        row_ok;
  logic                        col_ok;
  logic                        pool_ok;
  logic                        load_ok;
  logic                        in_fire;
  logic                        mem_we;
  logic [AW-1:0]               wr_addr;
  logic [PW-1:0]               ir;
  logic [PW-1:0]               ic;
  logic                        cell_ok;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic signed [SAMPLE_W-1:0]  scan_best;
  logic                        out_free;
  logic                        emit_fire;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit_fire     = (state == ST_EMIT) && out_free;

  // Configuration writes; unknown indexes fall through.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_height    <= 6'd1;
      map_width     <= 6'd1;
      channel_count <= 5'd1;
      kernel_height <= 4'd2;
      kernel_width  <= 4'd2;
      stride_rows   <= 4'd2;
      stride_cols   <= 4'd2;
      round_up      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAP_HEIGHT:    map_height    <= cfg_data;
        REG_MAP_WIDTH:     map_width     <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[4:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg_data[3:0];
        REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[3:0];
        REG_STRIDE_ROWS:   stride_rows   <= cfg_data[3:0];
        REG_STRIDE_COLS:   stride_cols   <= cfg_data[3:0];
        REG_ROUND_UP:      round_up      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Saturate the registers at the hardware limits; a zero stride acts as one.
  always_comb begin
    h_cap  = (map_height > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : map_height;
    w_cap  = (map_width > MAX_WIDTH) ? 6'(MAX_WIDTH) : map_width;
    nc_cap = (channel_count > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : channel_count;
    kh_cap = (kernel_height > MAX_KERNEL) ? 4'(MAX_KERNEL) : kernel_height;
    kw_cap = (kernel_width > MAX_KERNEL) ? 4'(MAX_KERNEL) : kernel_width;
    sr_cap = (stride_rows > MAX_STRIDE) ? 4'(MAX_STRIDE) : stride_rows;
    sc_cap = (stride_cols > MAX_STRIDE) ? 4'(MAX_STRIDE) : stride_cols;
    sr     = (sr_cap == 4'd0) ? 4'd1 : sr_cap;
    sc     = (sc_cap == 4'd0) ? 4'd1 : sc_cap;
  end

  // Input field extraction.
  assign in_row      = s_axis_tdata[ROW_LSB +: ROW_W];
  assign in_col      = s_axis_tdata[COL_LSB +: COL_W];
  assign in_chan     = s_axis_tdata[CHAN_LSB +: CHAN_W];
  assign in_sample   = s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
  assign row_ext     = PW'(in_row);
  assign col_ext     = PW'(in_col);
  assign chan_in_ext = PW'(in_chan);

  // Window origin and output-size test: row < out_size(h, s) is row * s < h
  // for ceiling division and row * s + s <= h for floor division.
  always_comb begin
    prod_r  = row_ext * PW'(sr);
    prod_c  = col_ext * PW'(sc);
    if (round_up) begin
      row_ok = prod_r < PW'(h_cap);
      col_ok = prod_c < PW'(w_cap);
    end else begin
      row_ok = (prod_r + PW'(sr)) <= PW'(h_cap);
      col_ok = (prod_c + PW'(sc)) <= PW'(w_cap);
    end
    pool_ok = row_ok && col_ok && (in_chan < nc_cap);
    load_ok = (row_ext < PW'(h_cap)) && (col_ext < PW'(w_cap)) && (in_chan < nc_cap);
  end

  // Load path: a sample inside the map is written on the cycle it is accepted.
  assign mem_we  = in_fire && (s_axis_tuser[0] == OP_LOAD) && load_ok;
  assign wr_addr = {row_ext[RB-1:0], col_ext[CB-1:0], chan_in_ext[HB-1:0]};

  // Scan address: one window cell per cycle, cells outside the map are not read.
  assign chan_ext = PW'(chan);
  always_comb begin
    ir      = base_r + PW'(i_cnt);
    ic      = base_c + PW'(j_cnt);
    cell_ok = (ir < PW'(h_cap)) && (ic < PW'(w_cap));
    rd_en   = (state == ST_SCAN) && cell_ok;
    rd_addr = {ir[RB-1:0], ic[CB-1:0], chan_ext[HB-1:0]};
  end

  // Fold the last sample read from the store into the running maximum.
  assign scan_best = (rd_live && (rd_data > best)) ? rd_data : best;

  // Feature store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      feature_mem[wr_addr] <= in_sample;
    end
    if (rd_en) begin
      rd_data <= feature_mem[rd_addr];
    end
  end

  // Sequencer: accept, walk the window row by row, then hand off the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_live       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Output register: load a finished result, or drop the one just taken.
      if (emit_fire) begin
        m_axis_tdata  <= scan_best;
        m_axis_tuser  <= in_ok;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire && (s_axis_tuser[0] == OP_POOL)) begin
            base_r  <= prod_r;
            base_c  <= prod_c;
            chan    <= in_chan;
            in_ok   <= pool_ok;
            best    <= SAMPLE_FLOOR;
            i_cnt   <= 4'd0;
            j_cnt   <= 4'd0;
            rd_live <= 1'b0;
            if (pool_ok && (kh_cap != 4'd0) && (kw_cap != 4'd0)) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          best    <= scan_best;
          rd_live <= cell_ok;
          if (j_cnt == kw_cap - 4'd1) begin
            j_cnt <= 4'd0;
            if (i_cnt == kh_cap - 4'd1) begin
              state <= ST_EMIT;
            end else begin
              i_cnt <= i_cnt + 4'd1;
            end
          end else begin
            j_cnt <= j_cnt + 4'd1;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            rd_live <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
